@@ src/sssq_pkg.sv @@
// Package: shared types and constants for the SPI save-memory sequencer.
package sssq_pkg;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_READ  = 2'd1,
        PH_WDATA = 2'd2,
        PH_POLL  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2,
        OP_ERASE = 2'd3
    } oper_t;

    localparam logic [2:0] REQ_READ  = 3'd0;
    localparam logic [2:0] REQ_WRITE = 3'd1;
    localparam logic [2:0] REQ_DATA  = 3'd2;
    localparam logic [2:0] REQ_RESP  = 3'd3;
    localparam logic [2:0] REQ_ERASE = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOMEM = 2'd1;
    localparam logic [1:0] ST_BUSY  = 2'd2;

    localparam logic [1:0] FE_KEEP  = 2'd0;
    localparam logic [1:0] FE_REL   = 2'd1;
    localparam logic [1:0] FE_CLOSE = 2'd2;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_SMALL = 2'd1;
    localparam logic [1:0] KIND_FLASH = 2'd3;

    localparam logic [7:0] CMD_READ  = 8'h03;
    localparam logic [7:0] CMD_WRITE = 8'h02;
    localparam logic [7:0] CMD_WREN  = 8'h06;
    localparam logic [7:0] CMD_RDSR  = 8'h05;
    localparam logic [7:0] CMD_SE    = 8'hd8;

    localparam int MAX_RES = 7;
    localparam int RES_W   = 3;

    // one result item
    typedef struct packed {
        logic       last;
        logic [1:0] status;
        logic       done_res;
        logic [7:0] rd_byte;
        logic       rd_valid;
        logic       expect_rx;
        logic [1:0] frame_end;
        logic       frame_start;
        logic [7:0] tx_byte;
        logic       tx_valid;
    } res_t;

    // a classified item: up to seven results
    typedef struct packed {
        logic [RES_W-1:0] count;
        res_t [MAX_RES-1:0] res;
    } batch_t;

endpackage

@@ src/spi_save_memory_sequencer.sv @@
// Top level of the SPI save-memory command sequencer.
// Usage:
//  s_* channel: one request per transaction. tdata = {data_byte, byte_count,
//   start_address, req_type} from bit 0 (51 bits, zero padded to 56).
//  m_* channel: one result per transaction. tdata = tx_valid, tx_byte,
//   frame_start, frame_end, expect_rx, rd_valid, rd_byte, done_res, status
//   from bit 0 (25 bits, padded to 32); tlast marks the last result of a
//   request.
//  cfg_*: memory_kind write, always accepted; used by the next request taken.
// Path: with the queue and output empty, an accepted request is written to the
//  batch queue, and its first result is then loaded into the output register.
// Throughput: the front end classifies one request per cycle while the queue
//  has room, into a batch of one to seven results; the back end sends one
//  result per cycle while m_tready is high, up to seven per request.
//  A two-entry batch queue lets the front take requests while the back drains.
// Reset: kind 0, sequencer idle, queue empty, no output valid.
// Stall: with m_tready low the output register holds; once the queue fills,
//  s_tready drops until the back end frees an entry.
module spi_save_memory_sequencer #(
    parameter int ADDR_WIDTH  = 24,
    parameter int COUNT_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // req_type, start_address, byte_count, data_byte
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,  // memory_kind
    output logic        m_tvalid,
    input  logic        m_tready,
    // tx_valid, tx_byte, frame_start, frame_end, expect_rx, rd_valid, rd_byte,
    // done_res, status
    output logic [31:0] m_tdata,
    output logic        m_tlast
);
    logic [1:0]       kind_reg;
    logic             in_fire, q_full, q_empty, q_pop;
    sssq_pkg::batch_t batch, q_data;
    sssq_pkg::res_t   res;

    always_ff @(posedge aclk) begin
        if (!aresetn) kind_reg <= sssq_pkg::KIND_NONE;
        else if (cfg_valid) kind_reg <= cfg_data;
    end
    assign cfg_ready = 1'b1;

    assign s_tready = !q_full;
    assign in_fire  = s_tvalid && s_tready;

    sssq_front #(.ADDR_WIDTH(ADDR_WIDTH), .COUNT_WIDTH(COUNT_WIDTH)) u_front (
        .aclk, .aresetn, .kind(kind_reg), .in_fire,
        .req_type(s_tdata[2:0]), .start_address(s_tdata[26:3]),
        .byte_count(s_tdata[42:27]), .data_byte(s_tdata[50:43]), .batch
    );

    sssq_queue u_queue (
        .aclk, .aresetn, .wr_en(in_fire), .wr_data(batch), .full(q_full),
        .rd_en(q_pop), .empty(q_empty), .rd_data(q_data)
    );

    sssq_back u_back (
        .aclk, .aresetn, .q_empty, .q_data, .q_pop,
        .m_valid(m_tvalid), .m_res(res), .m_ready(m_tready)
    );

    assign m_tdata = {7'd0, res.status, res.done_res, res.rd_byte, res.rd_valid,
                      res.expect_rx, res.frame_end, res.frame_start, res.tx_byte,
                      res.tx_valid};
    assign m_tlast = res.last;
endmodule

@@ src/sssq_front.sv @@
// Front end: classifies an item against sequencer state and builds its result batch.
module sssq_front #(
    parameter int ADDR_WIDTH  = 24,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [1:0]            kind,
    input  logic                  in_fire,
    input  logic [2:0]            req_type,
    input  logic [23:0]           start_address,
    input  logic [15:0]           byte_count,
    input  logic [7:0]            data_byte,
    output sssq_pkg::batch_t      batch
);
    localparam logic [ADDR_WIDTH-1:0]  AONE = {{(ADDR_WIDTH-1){1'b0}}, 1'b1};
    localparam logic [COUNT_WIDTH-1:0] CONE = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
    localparam logic [COUNT_WIDTH-1:0] CZERO = '0;

    sssq_pkg::phase_t phase_reg, phase_next;
    sssq_pkg::oper_t  oper_reg, oper_next;
    logic [ADDR_WIDTH-1:0]  addr_reg, addr_next;
    logic [COUNT_WIDTH-1:0] left_reg, left_next;
    logic [8:0]             fill_reg, fill_next;

    logic [ADDR_WIDTH-1:0]  in_addr;
    logic [COUNT_WIDTH-1:0] in_cnt;
    logic [23:0]            a24;
    logic [8:0]             csize;
    logic                   wend;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= sssq_pkg::PH_IDLE;
            oper_reg  <= sssq_pkg::OP_NONE;
            addr_reg  <= '0;
            left_reg  <= '0;
            fill_reg  <= '0;
        end else if (in_fire) begin
            phase_reg <= phase_next;
            oper_reg  <= oper_next;
            addr_reg  <= addr_next;
            left_reg  <= left_next;
            fill_reg  <= fill_next;
        end
    end

    always_comb begin
        sssq_pkg::res_t r;
        logic [2:0] n;
        logic [ADDR_WIDTH-1:0] ca;
        r = '0;
        n = '0;
        ca = '0;
        batch = '0;
        phase_next = phase_reg;
        oper_next  = oper_reg;
        addr_next  = addr_reg;
        left_next  = left_reg;
        fill_next  = fill_reg;
        in_addr = start_address[ADDR_WIDTH-1:0];
        in_cnt  = byte_count[COUNT_WIDTH-1:0];
        csize = (kind == sssq_pkg::KIND_SMALL) ? 9'd16 :
                (kind == sssq_pkg::KIND_FLASH) ? 9'd256 : 9'd32;
        a24 = '0;
        wend = 1'b0;

        case (req_type)
            sssq_pkg::REQ_READ, sssq_pkg::REQ_WRITE, sssq_pkg::REQ_ERASE: begin
                if (kind == sssq_pkg::KIND_NONE) begin
                    r = '0; r.status = sssq_pkg::ST_NOMEM;
                    batch.res[0] = r; n = 3'd1;
                end else if (phase_reg != sssq_pkg::PH_IDLE ||
                             (req_type == sssq_pkg::REQ_ERASE &&
                              kind != sssq_pkg::KIND_FLASH)) begin
                    r = '0; r.status = sssq_pkg::ST_BUSY;
                    batch.res[0] = r; n = 3'd1;
                end else if (req_type == sssq_pkg::REQ_ERASE) begin
                    r = '0; r.tx_valid = 1'b1; r.tx_byte = sssq_pkg::CMD_WREN;
                    r.frame_start = 1'b1; r.frame_end = sssq_pkg::FE_REL;
                    batch.res[0] = r;
                    r.tx_byte = sssq_pkg::CMD_SE; r.frame_end = sssq_pkg::FE_KEEP;
                    batch.res[1] = r;
                    r.frame_start = 1'b0; r.tx_byte = start_address[7:0];
                    batch.res[2] = r;
                    r.tx_byte = 8'h00;
                    batch.res[3] = r;
                    r.frame_end = sssq_pkg::FE_REL;
                    batch.res[4] = r;
                    r.frame_end = sssq_pkg::FE_KEEP; r.frame_start = 1'b1;
                    r.tx_byte = sssq_pkg::CMD_RDSR;
                    batch.res[5] = r;
                    r.frame_start = 1'b0; r.tx_byte = 8'h00; r.expect_rx = 1'b1;
                    batch.res[6] = r;
                    n = 3'd7;
                    oper_next = sssq_pkg::OP_ERASE;
                    left_next = '0;
                    phase_next = sssq_pkg::PH_POLL;
                end else if (req_type == sssq_pkg::REQ_WRITE && in_cnt == CZERO) begin
                    r = '0; r.done_res = 1'b1;
                    batch.res[0] = r; n = 3'd1;
                end else begin
                    ca = in_addr;
                    a24 = 24'(ca);
                    addr_next = in_addr;
                    left_next = in_cnt;
                    if (req_type == sssq_pkg::REQ_WRITE) begin
                        r = '0; r.tx_valid = 1'b1; r.tx_byte = sssq_pkg::CMD_WREN;
                        r.frame_start = 1'b1; r.frame_end = sssq_pkg::FE_REL;
                        batch.res[0] = r;
                        n = 3'd1;
                    end
                    r = '0; r.tx_valid = 1'b1; r.frame_start = 1'b1;
                    r.tx_byte = (req_type == sssq_pkg::REQ_WRITE) ?
                                sssq_pkg::CMD_WRITE : sssq_pkg::CMD_READ;
                    if (kind == sssq_pkg::KIND_SMALL)
                        r.tx_byte[3] = a24[8];
                    batch.res[n] = r; n = n + 3'd1;
                    r.frame_start = 1'b0;
                    if (kind == sssq_pkg::KIND_FLASH) begin
                        r.tx_byte = a24[23:16];
                        batch.res[n] = r; n = n + 3'd1;
                    end
                    if (kind != sssq_pkg::KIND_SMALL) begin
                        r.tx_byte = a24[15:8];
                        batch.res[n] = r; n = n + 3'd1;
                    end
                    r.tx_byte = a24[7:0];
                    if (req_type == sssq_pkg::REQ_READ && in_cnt == CZERO) begin
                        r.frame_end = sssq_pkg::FE_CLOSE; r.done_res = 1'b1;
                        batch.res[n] = r; n = n + 3'd1;
                    end else begin
                        batch.res[n] = r; n = n + 3'd1;
                        if (req_type == sssq_pkg::REQ_READ) begin
                            r = '0; r.tx_valid = 1'b1; r.expect_rx = 1'b1;
                            r.frame_end = (in_cnt == CONE) ? sssq_pkg::FE_CLOSE
                                                          : sssq_pkg::FE_KEEP;
                            batch.res[n] = r; n = n + 3'd1;
                            oper_next = sssq_pkg::OP_READ;
                            phase_next = sssq_pkg::PH_READ;
                        end else begin
                            oper_next = sssq_pkg::OP_WRITE;
                            fill_next = '0;
                            phase_next = sssq_pkg::PH_WDATA;
                        end
                    end
                end
            end
            sssq_pkg::REQ_DATA: begin
                if (phase_reg != sssq_pkg::PH_WDATA) begin
                    r = '0; r.status = sssq_pkg::ST_BUSY;
                    batch.res[0] = r; n = 3'd1;
                end else begin
                    addr_next = addr_reg + AONE;
                    left_next = left_reg - CONE;
                    fill_next = fill_reg + 9'd1;
                    wend = (fill_next >= csize) || (left_next == CZERO);
                    r = '0; r.tx_valid = 1'b1; r.tx_byte = data_byte;
                    r.frame_end = wend ? sssq_pkg::FE_REL : sssq_pkg::FE_KEEP;
                    batch.res[0] = r; n = 3'd1;
                    if (wend) begin
                        r = '0; r.tx_valid = 1'b1; r.tx_byte = sssq_pkg::CMD_RDSR;
                        r.frame_start = 1'b1;
                        batch.res[1] = r;
                        r.frame_start = 1'b0; r.tx_byte = 8'h00; r.expect_rx = 1'b1;
                        batch.res[2] = r;
                        n = 3'd3;
                        phase_next = sssq_pkg::PH_POLL;
                    end
                end
            end
            sssq_pkg::REQ_RESP: begin
                if (phase_reg == sssq_pkg::PH_READ) begin
                    left_next = left_reg - CONE;
                    r = '0; r.rd_valid = 1'b1; r.rd_byte = data_byte;
                    if (left_next == CZERO) begin
                        r.done_res = 1'b1;
                        phase_next = sssq_pkg::PH_IDLE;
                        oper_next = sssq_pkg::OP_NONE;
                    end else begin
                        r.tx_valid = 1'b1; r.expect_rx = 1'b1;
                        r.frame_end = (left_next == CONE) ? sssq_pkg::FE_CLOSE
                                                         : sssq_pkg::FE_KEEP;
                    end
                    batch.res[0] = r; n = 3'd1;
                end else if (phase_reg == sssq_pkg::PH_POLL) begin
                    if (data_byte[0]) begin
                        r = '0; r.tx_valid = 1'b1; r.expect_rx = 1'b1;
                        batch.res[0] = r; n = 3'd1;
                    end else if (oper_reg == sssq_pkg::OP_WRITE && left_reg != CZERO) begin
                        // next chunk: close poll, then write-enable and header
                        a24 = 24'(addr_reg);
                        r = '0; r.frame_end = sssq_pkg::FE_CLOSE;
                        batch.res[0] = r;
                        r = '0; r.tx_valid = 1'b1; r.tx_byte = sssq_pkg::CMD_WREN;
                        r.frame_start = 1'b1; r.frame_end = sssq_pkg::FE_REL;
                        batch.res[1] = r;
                        r.frame_end = sssq_pkg::FE_KEEP; r.tx_byte = sssq_pkg::CMD_WRITE;
                        if (kind == sssq_pkg::KIND_SMALL)
                            r.tx_byte[3] = a24[8];
                        batch.res[2] = r;
                        n = 3'd3;
                        r.frame_start = 1'b0;
                        if (kind == sssq_pkg::KIND_FLASH) begin
                            r.tx_byte = a24[23:16];
                            batch.res[n] = r; n = n + 3'd1;
                        end
                        if (kind != sssq_pkg::KIND_SMALL) begin
                            r.tx_byte = a24[15:8];
                            batch.res[n] = r; n = n + 3'd1;
                        end
                        r.tx_byte = a24[7:0];
                        batch.res[n] = r; n = n + 3'd1;
                        fill_next = '0;
                        phase_next = sssq_pkg::PH_WDATA;
                    end else begin
                        r = '0; r.frame_end = sssq_pkg::FE_CLOSE; r.done_res = 1'b1;
                        batch.res[0] = r; n = 3'd1;
                        phase_next = sssq_pkg::PH_IDLE;
                        oper_next = sssq_pkg::OP_NONE;
                        fill_next = '0;
                    end
                end else begin
                    r = '0; r.status = sssq_pkg::ST_BUSY;
                    batch.res[0] = r; n = 3'd1;
                end
            end
            default: begin
                r = '0; r.status = sssq_pkg::ST_BUSY;
                batch.res[0] = r; n = 3'd1;
            end
        endcase
        batch.res[n - 3'd1].last = 1'b1;
        batch.count = n;
    end
endmodule

@@ src/sssq_queue.sv @@
// Two-entry batch queue between front and back ends.
module sssq_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  sssq_pkg::batch_t wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic             empty,
    output sssq_pkg::batch_t rd_data
);
    sssq_pkg::batch_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (wr_en) wp_reg <= ~wp_reg;
            if (rd_en) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

    assign full    = cnt_reg[1];
    assign empty   = (cnt_reg == 2'd0);
    assign rd_data = mem_reg[rp_reg];
endmodule

@@ src/sssq_back.sv @@
// Back end: plays a batch out one result per transaction through an output register.
module sssq_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_empty,
    input  sssq_pkg::batch_t q_data,
    output logic             q_pop,
    output logic             m_valid,
    output sssq_pkg::res_t   m_res,
    input  logic             m_ready
);
    logic [sssq_pkg::RES_W-1:0] idx_reg;
    logic                       vld_reg;
    sssq_pkg::res_t             out_reg;
    logic                       load;

    assign load  = !q_empty && (!vld_reg || m_ready);
    assign q_pop = load && (idx_reg == q_data.count - 3'd1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            vld_reg <= 1'b0;
        end else begin
            if (load) begin
                vld_reg <= 1'b1;
                idx_reg <= q_pop ? '0 : idx_reg + 3'd1;
            end else if (m_ready) begin
                vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) out_reg <= q_data.res[idx_reg];
    end

    assign m_valid = vld_reg;
    assign m_res   = out_reg;
endmodule

@@ src/sssq_checker.sv @@
// Port-level checker for the sequencer, bound to the top level.
module sssq_props (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed while stalled");
    a_rej: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[24:23] != 2'd0 |-> m_tlast && !m_tdata[0])
        else $error("rejection not single result");
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[22] |-> m_tlast)
        else $error("done not last");
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> ##1 m_tvalid)
        else $error("result missing");
endmodule

bind spi_save_memory_sequencer sssq_props u_sssq_props (
    .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tlast
);
